>>> rtl/lcrc_pkg.sv
// Types, constants and helper functions for the line CRC-32 frame checker.
// Depends on nothing; every other file of the block but lcrc_intf imports it.
`timescale 1ns / 1ps

package lcrc_pkg;

  localparam int          MaxPayloadLenDef = 4095;
  localparam int          LenFieldMax      = 4095;
  localparam logic [31:0] CrcPoly          = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit          = 32'hFFFF_FFFF;

  localparam logic [7:0] CharNl   = 8'h0A;
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharXLo  = 8'h78;
  localparam logic [7:0] CharXUp  = 8'h58;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MARKER = 2'd1,
    ST_BAD_HEX   = 2'd2,
    ST_MISMATCH  = 2'd3
  } frame_status_e;

  typedef enum logic [2:0] {
    HEX_IDLE   = 3'd0,
    HEX_ZERO   = 3'd1,
    HEX_PREFIX = 3'd2,
    HEX_DIGITS = 3'd3,
    HEX_TRAIL  = 3'd4,
    HEX_BAD    = 3'd5
  } hex_phase_e;

  typedef struct packed {
    frame_status_e status;
    logic [31:0]   received_crc;
    logic [31:0]   computed_crc;
    logic [11:0]   payload_length;
  } lcrc_result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0B) || (b == 8'h0C);
  endfunction

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

>>> rtl/lcrc_intf.sv
// Handshake channels of the line CRC-32 frame checker: byte in, frame result out.
// Depends on nothing.
`timescale 1ns / 1ps

interface lcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcrc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [31:0] received_crc;
  logic [31:0] computed_crc;
  logic [11:0] payload_length;

  modport source (output valid, output frame_status, output received_crc,
                  output computed_crc, output payload_length, input ready);
  modport sink (input valid, input frame_status, input received_crc,
                input computed_crc, input payload_length, output ready);
endinterface

>>> rtl/lcrc_line_parser.sv
// Per-line state of the frame checker: CRC, star snapshot, hex parse, byte count.
// Depends on lcrc_pkg and lcrc_byte_if.
`timescale 1ns / 1ps

module lcrc_line_parser #(
  parameter int MaxPayloadLen = lcrc_pkg::MaxPayloadLenDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lcrc_byte_if.sink             in_i,
  input  logic                  space_i,
  output logic                  res_valid_o,
  output lcrc_pkg::lcrc_result_t res_o
);
  import lcrc_pkg::*;

  localparam int CntW = $clog2(MaxPayloadLen + 1);
  localparam int LenW = (CntW > 12) ? CntW : 12;

  logic [31:0]     crc_q, crc_d;
  logic [31:0]     mark_crc_q, mark_crc_d;
  logic            marker_q, marker_d;
  logic            started_q, started_d;
  logic [31:0]     acc_q, acc_d;
  hex_phase_e      phase_q, phase_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] mark_len_q, mark_len_d;

  logic            beat;
  logic [7:0]      b;
  logic            sp;
  logic            is_nl;
  logic [4:0]      dig;
  logic            hex_ok;
  logic [LenW-1:0] len_w;
  logic [31:0]     calc;

  assign in_i.ready = space_i;
  assign beat       = in_i.valid && space_i;
  assign b          = in_i.rx_byte;
  assign sp         = is_space(b);
  assign is_nl      = (b == CharNl);
  assign dig        = hex_digit(b);
  assign calc       = ~mark_crc_q;
  assign len_w      = LenW'(mark_len_q);
  assign hex_ok     = ((phase_q == HEX_ZERO) || (phase_q == HEX_DIGITS) ||
                       (phase_q == HEX_TRAIL)) && !ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      mark_crc_q <= CrcInit;
      marker_q   <= 1'b0;
      started_q  <= 1'b0;
      acc_q      <= 32'd0;
      phase_q    <= HEX_IDLE;
      ovf_q      <= 1'b0;
      count_q    <= '0;
      mark_len_q <= '0;
    end else begin
      crc_q      <= crc_d;
      mark_crc_q <= mark_crc_d;
      marker_q   <= marker_d;
      started_q  <= started_d;
      acc_q      <= acc_d;
      phase_q    <= phase_d;
      ovf_q      <= ovf_d;
      count_q    <= count_d;
      mark_len_q <= mark_len_d;
    end
  end

  always_comb begin
    crc_d      = crc_q;
    mark_crc_d = mark_crc_q;
    marker_d   = marker_q;
    started_d  = started_q;
    acc_d      = acc_q;
    phase_d    = phase_q;
    ovf_d      = ovf_q;
    count_d    = count_q;
    mark_len_d = mark_len_q;

    res_valid_o          = 1'b0;
    res_o.status         = ST_NO_MARKER;
    res_o.received_crc   = 32'd0;
    res_o.computed_crc   = 32'd0;
    res_o.payload_length = 12'd0;

    if (marker_q) begin
      res_o.computed_crc   = calc;
      res_o.payload_length = (len_w > LenW'(LenFieldMax)) ? 12'(LenFieldMax) : len_w[11:0];
      if (!hex_ok) begin
        res_o.status = ST_BAD_HEX;
      end else begin
        res_o.received_crc = acc_q;
        res_o.status       = (acc_q == calc) ? ST_OK : ST_MISMATCH;
      end
    end

    if (beat) begin
      if (is_nl) begin
        res_valid_o = started_q;
        crc_d       = CrcInit;
        mark_crc_d  = CrcInit;
        marker_d    = 1'b0;
        started_d   = 1'b0;
        acc_d       = 32'd0;
        phase_d     = HEX_IDLE;
        ovf_d       = 1'b0;
        count_d     = '0;
        mark_len_d  = '0;
      end else if (started_q || !sp) begin
        started_d = 1'b1;
        if (b == CharStar) begin
          mark_crc_d = crc_q;
          mark_len_d = count_q;
          marker_d   = 1'b1;
          acc_d      = 32'd0;
          phase_d    = HEX_IDLE;
          ovf_d      = 1'b0;
        end else if (marker_q) begin
          unique case (phase_q) inside
            HEX_IDLE: begin
              if (!sp) begin
                if (!dig[4]) begin
                  phase_d = HEX_BAD;
                end else begin
                  ovf_d   = ovf_q | (acc_q[31:28] != 4'd0);
                  acc_d   = {acc_q[27:0], dig[3:0]};
                  phase_d = (dig[3:0] == 4'd0) ? HEX_ZERO : HEX_DIGITS;
                end
              end
            end
            HEX_ZERO: begin
              if (sp) begin
                phase_d = HEX_TRAIL;
              end else if (b == CharXLo || b == CharXUp) begin
                phase_d = HEX_PREFIX;
              end else if (!dig[4]) begin
                phase_d = HEX_BAD;
              end else begin
                ovf_d   = ovf_q | (acc_q[31:28] != 4'd0);
                acc_d   = {acc_q[27:0], dig[3:0]};
                phase_d = HEX_DIGITS;
              end
            end
            HEX_PREFIX, HEX_DIGITS: begin
              if (sp && phase_q == HEX_DIGITS) begin
                phase_d = HEX_TRAIL;
              end else if (!dig[4]) begin
                phase_d = HEX_BAD;
              end else begin
                ovf_d   = ovf_q | (acc_q[31:28] != 4'd0);
                acc_d   = {acc_q[27:0], dig[3:0]};
                phase_d = HEX_DIGITS;
              end
            end
            HEX_TRAIL: begin
              if (!sp) begin
                phase_d = HEX_BAD;
              end
            end
            default: begin
              phase_d = HEX_BAD;
            end
          endcase
        end
        crc_d = crc_byte(crc_q, b);
        if (count_q < CntW'(MaxPayloadLen)) begin
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  a_ok_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OK) |-> (res_o.received_crc == res_o.computed_crc))
    else $error("ok status with differing CRCs");

  a_no_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_NO_MARKER) |->
    (res_o.computed_crc == 32'd0 && res_o.payload_length == 12'd0))
    else $error("no-marker result carries CRC or length");

  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && is_nl) |=> (!started_q && !marker_q && count_q == '0))
    else $error("line state not cleared after newline");

endmodule

>>> rtl/lcrc_out_skid.sv
// Result register with a skid stage for the frame checker's result channel.
// Depends on lcrc_pkg and lcrc_result_if.
`timescale 1ns / 1ps

module lcrc_out_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lcrc_pkg::lcrc_result_t data_i,
  output logic                   space_o,
  lcrc_result_if.source          res_o
);
  import lcrc_pkg::*;

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  lcrc_result_t out_q, out_d;
  lcrc_result_t skid_q, skid_d;
  logic         pop;

  assign space_o              = !skid_valid_q;
  assign pop                  = out_valid_q && res_o.ready;
  assign res_o.valid          = out_valid_q;
  assign res_o.frame_status   = out_q.status;
  assign res_o.received_crc   = out_q.received_crc;
  assign res_o.computed_crc   = out_q.computed_crc;
  assign res_o.payload_length = out_q.payload_length;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while the result register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
    else $error("skid stage did not move into the result register");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result beat changed");

endmodule

>>> rtl/line_crc32_frame_checker.sv
// Top level of the line CRC-32 frame checker: line parser and result skid stage.
// Depends on lcrc_pkg, lcrc_intf, lcrc_line_parser and lcrc_out_skid.
//
//   channel  | dir | payload                                                  | per beat
//   in_i     | in  | rx_byte                                                  | one byte
//   res_o    | out | frame_status, received_crc, computed_crc, payload_length | one line
//
// One byte per cycle while in_i.ready is high; the CRC update and hex shift finish in
// the cycle the byte is taken. Each result is registered and leaves the result register.
// A stalled result parks the next one in the skid stage; in_i.ready drops only when
// both are full. Empty or whitespace-only lines give no beat.
// Reset clears all line state and both output stages at once.
`timescale 1ns / 1ps

module line_crc32_frame_checker #(
  parameter int MaxPayloadLen = lcrc_pkg::MaxPayloadLenDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcrc_byte_if.sink     in_i,
  lcrc_result_if.source res_o
);
  import lcrc_pkg::*;

  logic         space;
  logic         push;
  lcrc_result_t result;

  lcrc_line_parser #(
    .MaxPayloadLen(MaxPayloadLen)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_i    (space),
    .res_valid_o(push),
    .res_o      (result)
  );

  lcrc_out_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (result),
    .space_o(space),
    .res_o  (res_o)
  );

endmodule

>>> sim/tb_line_crc32_frame_checker.sv
// Testbench for line_crc32_frame_checker: drives text lines byte by byte and checks
// every frame report against an in-bench line parser and CRC-32 predictor.
// Depends on lcrc_pkg, lcrc_intf and the RTL of the block.
`timescale 1ns / 1ps

module tb_line_crc32_frame_checker;
  import lcrc_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 400;
  localparam int HoldAfter   = 40;
  localparam int CalmWindow  = 1000;
  localparam int IdlePeriod  = 4000;
  localparam int RandomBytes = 1070;
  localparam int LongPayload = 200;

  typedef enum int {
    CUT_EMPTY,
    CUT_JUNK,
    CUT_OVERFLOW,
    CUT_SPACE,
    CUT_SIGN,
    CUT_NOSTAR
  } cut_e;

  logic clk_i;
  logic rst_ni;

  lcrc_byte_if   in_if ();
  lcrc_result_if res_if ();

  line_crc32_frame_checker u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if)
  );

  logic [31:0]  run_crc;
  logic [31:0]  snap_crc;
  logic [31:0]  hex_acc;
  logic [11:0]  run_len;
  logic [11:0]  snap_len;
  logic         star_seen;
  logic         text_started;
  logic         hex_ovf;
  hex_phase_e   hex_ph;

  lcrc_result_t frame_reports_q[$];
  logic [7:0]   line_bytes_q[$];

  int unsigned  errors       = 0;
  int unsigned  n_checked    = 0;
  int unsigned  cyc          = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  hold_left    = 0;
  bit           hold_done    = 1'b0;

  function automatic bit is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic [31:0] crc_shift_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d, input bit up);
    return (d < 4'd10) ? 8'h30 + 8'(d) : (up ? 8'h37 : 8'h57) + 8'(d);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0D;
      3: return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  function automatic bit idle_roll();
    return (cyc % IdlePeriod >= CalmWindow) && ($urandom_range(0, 99) < 17);
  endfunction

  task automatic clear_line_state();
    run_crc      = CrcInit;
    snap_crc     = CrcInit;
    hex_acc      = 32'd0;
    run_len      = 12'd0;
    snap_len     = 12'd0;
    star_seen    = 1'b0;
    text_started = 1'b0;
    hex_ovf      = 1'b0;
    hex_ph       = HEX_IDLE;
  endtask

  task automatic shift_in_nibble(input logic [3:0] d);
    if (hex_acc[31:28] != 4'd0) begin
      hex_ovf = 1'b1;
    end
    hex_acc = {hex_acc[27:0], d};
  endtask

  task automatic feed_hex(input logic [7:0] b);
    int d;
    bit sp;
    d  = hex_nibble(b);
    sp = is_blank(b);
    case (hex_ph) inside
      HEX_IDLE: begin
        if (!sp) begin
          if (d < 0) begin
            hex_ph = HEX_BAD;
          end else begin
            shift_in_nibble(d[3:0]);
            hex_ph = (d == 0) ? HEX_ZERO : HEX_DIGITS;
          end
        end
      end
      HEX_ZERO: begin
        if (sp) begin
          hex_ph = HEX_TRAIL;
        end else if (b == CharXLo || b == CharXUp) begin
          hex_ph = HEX_PREFIX;
        end else if (d < 0) begin
          hex_ph = HEX_BAD;
        end else begin
          shift_in_nibble(d[3:0]);
          hex_ph = HEX_DIGITS;
        end
      end
      HEX_PREFIX, HEX_DIGITS: begin
        if (sp && hex_ph == HEX_DIGITS) begin
          hex_ph = HEX_TRAIL;
        end else if (d < 0) begin
          hex_ph = HEX_BAD;
        end else begin
          shift_in_nibble(d[3:0]);
          hex_ph = HEX_DIGITS;
        end
      end
      HEX_TRAIL: begin
        if (!sp) begin
          hex_ph = HEX_BAD;
        end
      end
      default: hex_ph = HEX_BAD;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b);
    lcrc_result_t r;
    if (b == CharNl) begin
      if (text_started) begin
        r.status         = ST_NO_MARKER;
        r.received_crc   = 32'd0;
        r.computed_crc   = 32'd0;
        r.payload_length = 12'd0;
        if (star_seen) begin
          r.computed_crc   = ~snap_crc;
          r.payload_length = snap_len;
          if (hex_ph inside {HEX_ZERO, HEX_DIGITS, HEX_TRAIL} && !hex_ovf) begin
            r.received_crc = hex_acc;
            r.status       = (hex_acc == ~snap_crc) ? ST_OK : ST_MISMATCH;
          end else begin
            r.status = ST_BAD_HEX;
          end
        end
        frame_reports_q.push_back(r);
      end
      clear_line_state();
    end else if (text_started || !is_blank(b)) begin
      text_started = 1'b1;
      if (b == CharStar) begin
        snap_crc  = run_crc;
        snap_len  = run_len;
        star_seen = 1'b1;
        hex_acc   = 32'd0;
        hex_ph    = HEX_IDLE;
        hex_ovf   = 1'b0;
      end else if (star_seen) begin
        feed_hex(b);
      end
      run_crc = crc_shift_byte(run_crc, b);
      if (int'(run_len) < MaxPayloadLenDef) begin
        run_len = run_len + 12'd1;
      end
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_bytes_q.push_back(s[i]);
    end
  endtask

  // Build one line: optional indent, payload, star and hex CRC unless cut, newline.
  task automatic add_frame(input int unsigned plen, input bit broken);
    logic [7:0]  ln[$];
    logic [7:0]  hx[$];
    logic [7:0]  b;
    logic [31:0] v;
    int          nd;
    bit          go;
    bit          keep_star;
    cut_e        cut;
    keep_star = 1'b1;
    go        = 1'b0;
    repeat ($urandom_range(0, 2)) ln.push_back(blank_byte());
    repeat (plen) begin
      b = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      if (b == CharNl) begin
        b = CharStar;
      end
      ln.push_back(b);
    end
    v = CrcInit;
    foreach (ln[i]) begin
      if (go || !is_blank(ln[i])) begin
        go = 1'b1;
        v  = crc_shift_byte(v, ln[i]);
      end
    end
    v = ~v;
    if ($urandom_range(0, 99) < 15) begin
      v = $urandom;
    end
    nd = 8;
    while (nd > 1 && v[4*nd-1 -: 4] == 4'h0) nd--;
    if ($urandom_range(0, 2) == 0) begin
      nd = $urandom_range(8, 10);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      hx.push_back(hex_char((i < 8) ? v[4*i +: 4] : 4'h0, $urandom_range(0, 1)));
    end
    if (broken) begin
      cut = cut_e'($urandom_range(0, 5));
      case (cut)
        CUT_EMPTY: hx.delete();
        CUT_JUNK: begin
          b = 8'($urandom_range(0, 255));
          if (b == CharNl) begin
            b = 8'h47;
          end
          hx.insert($urandom_range(0, hx.size()), b);
        end
        CUT_OVERFLOW: begin
          while (hx.size() < 8) hx.push_front(8'h30);
          hx.push_front(hex_char(4'($urandom_range(1, 15)), $urandom_range(0, 1)));
        end
        CUT_SPACE: hx.insert($urandom_range(0, hx.size()), blank_byte());
        CUT_SIGN: hx.push_front($urandom_range(0, 1) ? 8'h2D : 8'h2B);
        default: keep_star = 1'b0;
      endcase
    end
    if (keep_star) begin
      ln.push_back(CharStar);
      repeat ($urandom_range(0, 1)) ln.push_back(blank_byte());
      case ($urandom_range(0, 3))
        0: begin
          ln.push_back(8'h30);
          ln.push_back(CharXLo);
        end
        1: begin
          ln.push_back(8'h30);
          ln.push_back(CharXUp);
        end
        default: ;
      endcase
      foreach (hx[i]) ln.push_back(hx[i]);
      repeat ($urandom_range(0, 2)) ln.push_back(blank_byte());
    end
    ln.push_back(CharNl);
    foreach (ln[i]) line_bytes_q.push_back(ln[i]);
  endtask

  task automatic report_diff(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        take_byte(in_if.rx_byte);
      end
      if (!in_if.valid || in_if.ready) begin
        if (line_bytes_q.size() != 0 && !idle_roll()) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= line_bytes_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    lcrc_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (frame_reports_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual status %0d rx %h calc %h len %0d",
                   $time, res_if.frame_status, res_if.received_crc, res_if.computed_crc,
                   res_if.payload_length);
          errors++;
        end else begin
          want = frame_reports_q.pop_front();
          report_diff("frame_status", 32'(want.status), 32'(res_if.frame_status));
          report_diff("received_crc", want.received_crc, res_if.received_crc);
          report_diff("computed_crc", want.computed_crc, res_if.computed_crc);
          report_diff("payload_length", 32'(want.payload_length), 32'(res_if.payload_length));
          n_checked++;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && n_checked >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !idle_roll();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no beat for %0d cycles", $time, stall_cycles);
        $display("FAIL line_crc32_frame_checker");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int base;
    int pick;
    rst_ni = 1'b0;
    clear_line_state();

    push_text("\n");
    line_bytes_q.push_back(8'h20);
    line_bytes_q.push_back(8'h09);
    line_bytes_q.push_back(8'h0D);
    line_bytes_q.push_back(8'h0B);
    line_bytes_q.push_back(8'h0C);
    line_bytes_q.push_back(CharNl);
    push_text("no star here\n");
    push_text("*\n");
    push_text("*0\n");
    push_text("123456789*CBF43926\n");
    push_text(" \t123456789*0xcbf43926 \t\n");
    push_text("123456789* 0XCbF43926\r\n");
    push_text("123456789*00000000CBF43926\n");
    push_text("123456789*1CBF43926\n");
    push_text("123456789*0x\n");
    push_text("123456789*0\n");
    push_text("123456789*0 \n");
    push_text("123456789*0 1\n");
    push_text("123456789*-CBF43926\n");
    push_text("123456789*CBF4 3926\n");
    push_text("123456789*CBF4392G\n");
    push_text("123*456*789*12345678\n");
    push_text("123456789*CBF43927\n");
    push_text("x*0x0x1\n");
    line_bytes_q.push_back(8'h00);
    line_bytes_q.push_back(8'hFF);
    line_bytes_q.push_back(8'h80);
    line_bytes_q.push_back(8'h7F);
    push_text("*FFFFFFFF\n");

    add_frame(LongPayload, 1'b0);
    base = line_bytes_q.size();
    while (line_bytes_q.size() < base + RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_frame($urandom_range(0, 14), 1'b0);
      end else if (pick < 85) begin
        add_frame($urandom_range(0, 14), 1'b1);
      end else begin
        repeat ($urandom_range(0, 30)) line_bytes_q.push_back(8'($urandom_range(0, 255)));
        line_bytes_q.push_back(CharNl);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (line_bytes_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (errors == 0 && frame_reports_q.size() == 0) begin
      $display("PASS line_crc32_frame_checker");
    end else begin
      if (frame_reports_q.size() != 0) begin
        $display("%0t: %0d frame reports never arrived", $time, frame_reports_q.size());
      end
      $display("FAIL line_crc32_frame_checker");
    end
    $finish;
  end

endmodule
